FILE: rtl/grp_pkg.sv
// grp_pkg: types and constants shared by the guillotine rectangle packer
// used by the channel interfaces, the fit unit and the top level
package grp_pkg;

  localparam int COORD_BITS    = 13;
  localparam int PSIZE_BITS    = COORD_BITS + 1;
  localparam int PAD_BITS      = 8;
  localparam int POS_BITS      = 12;
  localparam int NUM_BITS      = 6;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PACK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_W   = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_H   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAD       = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALLOW_ROT = 8'd3;

  localparam logic [COORD_BITS-1:0] ATLAS_RESET = 13'd1024;

  typedef struct packed {
    logic [1:0]            action;
    logic [COORD_BITS-1:0] sprite_width;
    logic [COORD_BITS-1:0] sprite_height;
  } in_item_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]   sprite_number;
    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic [COORD_BITS-1:0] placed_width;
    logic [COORD_BITS-1:0] placed_height;
    logic                  turned;
    logic                  fitted;
    logic                  last_result;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

  typedef struct packed {
    logic                  take;
    logic                  rot;
    logic [COORD_BITS-1:0] ss;
  } fit_res_t;

endpackage

FILE: rtl/grp_in_if.sv
// grp_in_if: input channel carrying one command beat
// depends on grp_pkg
interface grp_in_if;
  logic               valid;
  logic               ready;
  grp_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/grp_out_if.sv
// grp_out_if: result channel carrying one placement beat
// depends on grp_pkg
interface grp_out_if;
  logic               valid;
  logic               ready;
  grp_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/grp_cfg_if.sv
// grp_cfg_if: register write channel, index plus data
// depends on grp_pkg
interface grp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [grp_pkg::CFG_IDX_BITS-1:0]    index;
  logic [grp_pkg::CFG_DATA_BITS-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/grp_ram.sv
// grp_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module grp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

FILE: rtl/grp_fit_eval.sv
// grp_fit_eval: best short side fit compare unit for one free rectangle
// depends on grp_pkg; shared by every step of the free list scan
module grp_fit_eval (
  input  grp_pkg::rect_t                      rect,
  input  logic [grp_pkg::PSIZE_BITS-1:0]      pw,
  input  logic [grp_pkg::PSIZE_BITS-1:0]      ph,
  input  logic                                rot_en,
  input  logic                                found,
  input  logic [grp_pkg::COORD_BITS-1:0]      best,
  output grp_pkg::fit_res_t                   res
);
  import grp_pkg::*;

  logic [PSIZE_BITS-1:0] fw, fh;
  logic                  fit_n, fit_r, upd_n, upd_r, f1;
  logic [COORD_BITS-1:0] dwn, dhn, dwr, dhr, ssn, ssr, b1;

  always_comb begin
    fw    = PSIZE_BITS'(rect.w);
    fh    = PSIZE_BITS'(rect.h);
    fit_n = (pw <= fw) && (ph <= fh);
    fit_r = rot_en && (ph <= fw) && (pw <= fh);
    dwn   = COORD_BITS'(fw - pw);
    dhn   = COORD_BITS'(fh - ph);
    dwr   = COORD_BITS'(fw - ph);
    dhr   = COORD_BITS'(fh - pw);
    ssn   = (dwn < dhn) ? dwn : dhn;
    ssr   = (dwr < dhr) ? dwr : dhr;
    // upright first, turned must be strictly better
    upd_n = fit_n && (!found || ssn < best);
    f1    = found || upd_n;
    b1    = upd_n ? ssn : best;
    upd_r = fit_r && (!f1 || ssr < b1);
    res.take = upd_n || upd_r;
    res.rot  = upd_r;
    res.ss   = upd_r ? ssr : b1;
  end
endmodule

FILE: rtl/guillotine_rect_packer_top.sv
// guillotine_rect_packer_top: sprite list, area ordering and guillotine placement
// depends on grp_pkg, grp_in_if, grp_out_if, grp_cfg_if, grp_ram, grp_fit_eval
//
// channel | dir | beat
// in_ch   | in  | action, sprite_width, sprite_height
// out_ch  | out | one placement per loaded sprite on pack
// cfg_ch  | in  | register index and data, always ready
//
// load and clear are taken while idle. pack runs, per sprite, an area scan
// over the loaded sprites, a fit scan over the free rects through the shared
// fit unit, the result beat, then removal of the chosen rect and its split
// into a right and a bottom part. the input is not ready until the whole
// pack is done and the result beat is held while the sink stalls. reset is
// synchronous, no sweep.
module guillotine_rect_packer_top #(
  parameter int MAX_SPRITES    = 64,
  parameter int MAX_FREE_RECTS = 65
) (
  input  logic        clk,
  input  logic        rst_n,
  grp_in_if.sink      in_ch,
  grp_out_if.source   out_ch,
  grp_cfg_if.sink     cfg_ch
);
  import grp_pkg::*;

  localparam int SW  = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int CW  = $clog2(MAX_SPRITES + 1);
  localparam int FW  = (MAX_FREE_RECTS > 1) ? $clog2(MAX_FREE_RECTS) : 1;
  localparam int FCW = $clog2(MAX_FREE_RECTS + 1);
  localparam int AB  = 2 * COORD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEL  = 4'd1;
  localparam logic [3:0] S_FIT  = 4'd2;
  localparam logic [3:0] S_OUT  = 4'd3;
  localparam logic [3:0] S_SHF  = 4'd4;
  localparam logic [3:0] S_APP1 = 4'd5;
  localparam logic [3:0] S_APP2 = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;

  logic [3:0]              state_r, state_nxt;
  logic [COORD_BITS-1:0]   aw_r, aw_nxt, ah_r, ah_nxt;
  logic [PAD_BITS-1:0]     pad_r, pad_nxt;
  logic                    rot_r, rot_nxt;
  logic [CW-1:0]           scnt_r, scnt_nxt, k_r, k_nxt, sc_r, sc_nxt;
  logic [MAX_SPRITES-1:0]  used_r, used_nxt;
  logic                    sv_r, sv_nxt, have_r, have_nxt;
  logic [SW-1:0]           si_r, si_nxt, bsel_r, bsel_nxt;
  logic [AB-1:0]           barea_r, barea_nxt, area;
  logic [COORD_BITS-1:0]   bw_r, bw_nxt, bh_r, bh_nxt;
  logic [PSIZE_BITS-1:0]   pw_r, pw_nxt, ph_r, ph_nxt, uw, uh;
  logic [FCW-1:0]          fcnt_r, fcnt_nxt, fsc_r, fsc_nxt;
  logic                    fsv_r, fsv_nxt, found_r, found_nxt, brot_r, brot_nxt;
  logic [FW-1:0]           fsi_r, fsi_nxt, bi_r, bi_nxt;
  logic [COORD_BITS-1:0]   best_r, best_nxt;
  rect_t                   brect_r, brect_nxt, frd;
  logic                    out_vld_r, out_vld_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic                    s_we, f_we;
  logic [SW-1:0]           s_waddr, s_raddr;
  logic [AB-1:0]           s_wdata, s_rdata;
  logic [FW-1:0]           f_waddr, f_raddr;
  rect_t                   f_wdata;
  logic [4*COORD_BITS-1:0] f_rdata;
  fit_res_t                fit;
  logic                    in_acc, out_acc;
  logic [COORD_BITS-1:0]   sw_s, sh_s;

  grp_ram #(.WIDTH(AB), .DEPTH(MAX_SPRITES)) u_sprite_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata_r(s_rdata)
  );

  grp_ram #(.WIDTH(4 * COORD_BITS), .DEPTH(MAX_FREE_RECTS)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata_r(f_rdata)
  );

  assign frd = rect_t'(f_rdata);

  grp_fit_eval u_fit (
    .rect(frd), .pw(pw_r), .ph(ph_r), .rot_en(rot_r),
    .found(found_r), .best(best_r), .res(fit)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld_r;
  assign out_ch.item  = out_item_r;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_vld_r && out_ch.ready;

  assign area = AB'(s_rdata[AB-1:COORD_BITS]) * AB'(s_rdata[COORD_BITS-1:0]);
  assign uw   = brot_r ? ph_r : pw_r;
  assign uh   = brot_r ? pw_r : ph_r;
  assign sw_s = brot_r ? bh_r : bw_r;
  assign sh_s = brot_r ? bw_r : bh_r;

  always_comb begin
    state_nxt    = state_r;
    aw_nxt       = aw_r;
    ah_nxt       = ah_r;
    pad_nxt      = pad_r;
    rot_nxt      = rot_r;
    scnt_nxt     = scnt_r;
    k_nxt        = k_r;
    sc_nxt       = sc_r;
    used_nxt     = used_r;
    sv_nxt       = 1'b0;
    si_nxt       = si_r;
    have_nxt     = have_r;
    bsel_nxt     = bsel_r;
    barea_nxt    = barea_r;
    bw_nxt       = bw_r;
    bh_nxt       = bh_r;
    pw_nxt       = pw_r;
    ph_nxt       = ph_r;
    fcnt_nxt     = fcnt_r;
    fsc_nxt      = fsc_r;
    fsv_nxt      = 1'b0;
    fsi_nxt      = fsi_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    bi_nxt       = bi_r;
    brot_nxt     = brot_r;
    brect_nxt    = brect_r;
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    s_we         = 1'b0;
    s_waddr      = scnt_r[SW-1:0];
    s_wdata      = {in_ch.item.sprite_width, in_ch.item.sprite_height};
    s_raddr      = sc_r[SW-1:0];
    f_we         = 1'b0;
    f_waddr      = '0;
    f_wdata      = '{x: '0, y: '0, w: aw_r, h: ah_r};
    f_raddr      = fsc_r[FW-1:0];

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ATLAS_W:   aw_nxt  = cfg_ch.data[COORD_BITS-1:0];
        CFG_ATLAS_H:   ah_nxt  = cfg_ch.data[COORD_BITS-1:0];
        CFG_PAD:       pad_nxt = cfg_ch.data[PAD_BITS-1:0];
        CFG_ALLOW_ROT: rot_nxt = cfg_ch.data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.item.action)
            ACT_LOAD: begin
              if (scnt_r < CW'(MAX_SPRITES)) begin
                s_we     = 1'b1;
                scnt_nxt = scnt_r + 1'b1;
              end
            end
            ACT_PACK: begin
              if (scnt_r != '0) begin
                f_we      = 1'b1;
                fcnt_nxt  = FCW'(1);
                used_nxt  = '0;
                k_nxt     = '0;
                sc_nxt    = '0;
                have_nxt  = 1'b0;
                state_nxt = S_SEL;
              end
            end
            ACT_CLEAR: scnt_nxt = '0;
            default: ;
          endcase
        end
      end
      S_SEL: begin
        // largest unpadded area among unplaced sprites, lowest index on ties
        if (sc_r < scnt_r) begin
          sc_nxt = sc_r + 1'b1;
          sv_nxt = 1'b1;
          si_nxt = sc_r[SW-1:0];
        end
        if (sv_r && !used_r[si_r] && (!have_r || area > barea_r)) begin
          have_nxt  = 1'b1;
          barea_nxt = area;
          bsel_nxt  = si_r;
          bw_nxt    = s_rdata[AB-1:COORD_BITS];
          bh_nxt    = s_rdata[COORD_BITS-1:0];
        end
        if (sc_r == scnt_r && !sv_r) begin
          pw_nxt    = PSIZE_BITS'(bw_r) + PSIZE_BITS'({pad_r, 1'b0});
          ph_nxt    = PSIZE_BITS'(bh_r) + PSIZE_BITS'({pad_r, 1'b0});
          fsc_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        if (fsc_r < fcnt_r) begin
          fsc_nxt = fsc_r + 1'b1;
          fsv_nxt = 1'b1;
          fsi_nxt = fsc_r[FW-1:0];
        end
        if (fsv_r && fit.take) begin
          found_nxt = 1'b1;
          best_nxt  = fit.ss;
          bi_nxt    = fsi_r;
          brot_nxt  = fit.rot;
          brect_nxt = frd;
        end
        if (fsc_r == fcnt_r && !fsv_r) begin
          out_item_nxt.sprite_number = NUM_BITS'(bsel_r);
          out_item_nxt.last_result   = (k_r + 1'b1 == scnt_r);
          out_item_nxt.fitted        = found_r;
          out_item_nxt.turned        = found_r && brot_r;
          out_item_nxt.pos_x         = '0;
          out_item_nxt.pos_y         = '0;
          out_item_nxt.placed_width  = '0;
          out_item_nxt.placed_height = '0;
          if (found_r) begin
            out_item_nxt.pos_x = POS_BITS'(brect_r.x + COORD_BITS'(pad_r));
            out_item_nxt.pos_y = POS_BITS'(brect_r.y + COORD_BITS'(pad_r));
            out_item_nxt.placed_width  = sw_s;
            out_item_nxt.placed_height = sh_s;
          end
          out_vld_nxt = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          out_vld_nxt = 1'b0;
          if (found_r) begin
            fsc_nxt   = FCW'(bi_r) + 1'b1;
            state_nxt = S_SHF;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_SHF: begin
        // close the gap left by the used rectangle, keeping list order
        if (fsc_r < fcnt_r) begin
          fsc_nxt = fsc_r + 1'b1;
          fsv_nxt = 1'b1;
          fsi_nxt = fsc_r[FW-1:0];
        end
        if (fsv_r) begin
          f_we    = 1'b1;
          f_waddr = fsi_r - 1'b1;
          f_wdata = frd;
        end
        if (fsc_r == fcnt_r && !fsv_r) begin
          fcnt_nxt  = fcnt_r - 1'b1;
          state_nxt = S_APP1;
        end
      end
      S_APP1: begin
        // right part
        f_waddr = fcnt_r[FW-1:0];
        f_wdata = '{x: brect_r.x + COORD_BITS'(uw), y: brect_r.y,
                    w: brect_r.w - COORD_BITS'(uw), h: COORD_BITS'(uh)};
        if (PSIZE_BITS'(brect_r.w) > uw && uh != '0 &&
            fcnt_r < FCW'(MAX_FREE_RECTS)) begin
          f_we     = 1'b1;
          fcnt_nxt = fcnt_r + 1'b1;
        end
        state_nxt = S_APP2;
      end
      S_APP2: begin
        // bottom part
        f_waddr = fcnt_r[FW-1:0];
        f_wdata = '{x: brect_r.x, y: brect_r.y + COORD_BITS'(uh),
                    w: brect_r.w, h: brect_r.h - COORD_BITS'(uh)};
        if (PSIZE_BITS'(brect_r.h) > uh && brect_r.w != '0 &&
            fcnt_r < FCW'(MAX_FREE_RECTS)) begin
          f_we     = 1'b1;
          fcnt_nxt = fcnt_r + 1'b1;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        used_nxt[bsel_r] = 1'b1;
        k_nxt            = k_r + 1'b1;
        sc_nxt           = '0;
        have_nxt         = 1'b0;
        state_nxt        = (k_r + 1'b1 == scnt_r) ? S_IDLE : S_SEL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      aw_r      <= ATLAS_RESET;
      ah_r      <= ATLAS_RESET;
      pad_r     <= '0;
      rot_r     <= 1'b0;
      scnt_r    <= '0;
      fcnt_r    <= '0;
      k_r       <= '0;
      sc_r      <= '0;
      fsc_r     <= '0;
      sv_r      <= 1'b0;
      fsv_r     <= 1'b0;
      have_r    <= 1'b0;
      found_r   <= 1'b0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      aw_r      <= aw_nxt;
      ah_r      <= ah_nxt;
      pad_r     <= pad_nxt;
      rot_r     <= rot_nxt;
      scnt_r    <= scnt_nxt;
      fcnt_r    <= fcnt_nxt;
      k_r       <= k_nxt;
      sc_r      <= sc_nxt;
      fsc_r     <= fsc_nxt;
      sv_r      <= sv_nxt;
      fsv_r     <= fsv_nxt;
      have_r    <= have_nxt;
      found_r   <= found_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    bsel_r     <= bsel_nxt;
    barea_r    <= barea_nxt;
    bw_r       <= bw_nxt;
    bh_r       <= bh_nxt;
    pw_r       <= pw_nxt;
    ph_r       <= ph_nxt;
    fsi_r      <= fsi_nxt;
    best_r     <= best_nxt;
    bi_r       <= bi_nxt;
    brot_r     <= brot_nxt;
    brect_r    <= brect_nxt;
    out_item_r <= out_item_nxt;
  end
endmodule

FILE: bench/grp_tb_pkg.sv
// grp_tb_pkg: placement predictor state and routines for the packer bench
// depends on grp_pkg
`timescale 1ns / 1ps
package grp_tb_pkg;
  import grp_pkg::*;

  localparam int SPRITE_CAP = 64;
  localparam int FREE_CAP   = 65;

  // action code with no meaning, the block must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    longint x, y, w, h;
  } box_t;

  // predictor state, mirrors the block
  longint atlas_w = 1024, atlas_h = 1024, pad = 0, rot_en = 0;
  longint spr_w [SPRITE_CAP];
  longint spr_h [SPRITE_CAP];
  int     spr_count = 0;
  out_item_t placements_due[$];

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
    case (idx)
      CFG_ATLAS_W:   atlas_w = val & 16'h1fff;
      CFG_ATLAS_H:   atlas_h = val & 16'h1fff;
      CFG_PAD:       pad = val & 8'hff;
      CFG_ALLOW_ROT: rot_en = val & 1;
      default: ;
    endcase
  endfunction

  function automatic void add_box(ref box_t fl[$], input longint x, y, w, h);
    box_t b;
    if (w == 0 || h == 0 || fl.size() >= FREE_CAP) return;
    b.x = x; b.y = y; b.w = w; b.h = h;
    fl.insert(fl.size(), b);
  endfunction

  function automatic void predict_pack();
    int order[$];
    box_t fl[$];
    box_t f, b0;
    int j, s, bi;
    longint pw, ph, ss, best, uw, uh;
    bit found, rot;
    out_item_t r;
    if (spr_count == 0) return;
    // stable insertion, largest area first
    for (int i = 0; i < spr_count; i++) begin
      j = order.size();
      while (j > 0 && spr_w[order[j-1]] * spr_h[order[j-1]] < spr_w[i] * spr_h[i]) j--;
      order.insert(j, i);
    end
    b0.x = 0; b0.y = 0; b0.w = atlas_w; b0.h = atlas_h;
    fl.insert(fl.size(), b0);
    for (int k = 0; k < spr_count; k++) begin
      s = order[k];
      pw = spr_w[s] + 2 * pad;
      ph = spr_h[s] + 2 * pad;
      found = 0; rot = 0; best = 0; bi = 0;
      for (int i = 0; i < fl.size(); i++) begin
        f = fl[i];
        if (pw <= f.w && ph <= f.h) begin
          ss = (f.w - pw < f.h - ph) ? f.w - pw : f.h - ph;
          if (!found || ss < best) begin
            found = 1; best = ss; bi = i; rot = 0;
          end
        end
        if (rot_en != 0 && ph <= f.w && pw <= f.h) begin
          ss = (f.w - ph < f.h - pw) ? f.w - ph : f.h - pw;
          if (!found || ss < best) begin
            found = 1; best = ss; bi = i; rot = 1;
          end
        end
      end
      r = '0;
      r.sprite_number = NUM_BITS'(s);
      r.last_result = (k + 1 == spr_count);
      if (found) begin
        f = fl[bi];
        uw = rot ? ph : pw;
        uh = rot ? pw : ph;
        r.pos_x = POS_BITS'(f.x + pad);
        r.pos_y = POS_BITS'(f.y + pad);
        r.placed_width = COORD_BITS'(rot ? spr_h[s] : spr_w[s]);
        r.placed_height = COORD_BITS'(rot ? spr_w[s] : spr_h[s]);
        r.turned = rot;
        r.fitted = 1;
        fl.delete(bi);
        if (f.w > uw) add_box(fl, f.x + uw, f.y, f.w - uw, uh);
        if (f.h > uh) add_box(fl, f.x, f.y + uh, f.w, f.h - uh);
      end
      placements_due.insert(placements_due.size(), r);
    end
  endfunction

  function automatic void predict_command(in_item_t c);
    case (c.action)
      ACT_LOAD: if (spr_count < SPRITE_CAP) begin
        spr_w[spr_count] = c.sprite_width;
        spr_h[spr_count] = c.sprite_height;
        spr_count++;
      end
      ACT_PACK:  predict_pack();
      ACT_CLEAR: spr_count = 0;
      default: ;
    endcase
  endfunction
endpackage

FILE: bench/testbench.sv
// testbench: checks the guillotine packer against its own placement predictor
// depends on grp_pkg, grp_tb_pkg, the channel interfaces and the top level
`timescale 1ns / 1ps
module testbench;
  import grp_pkg::*;
  import grp_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fails = 0;
  int   hold_off = 0;
  bit   no_stall = 0;

  grp_in_if  in_ch ();
  grp_out_if out_ch ();
  grp_cfg_if cfg_ch ();

  guillotine_rect_packer_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.item = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 0;
  end

  // receiver stall pattern, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else if (no_stall) begin
      out_ch.ready <= 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.item;
      if (placements_due.size() == 0) begin
        $error("unexpected placement beat %p", got);
        fails++;
      end else begin
        want = placements_due.pop_front();
        if (got.sprite_number !== want.sprite_number) begin
          $error("sprite_number exp %0d got %0d", want.sprite_number, got.sprite_number);
          fails++;
        end
        if (got.pos_x !== want.pos_x) begin
          $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x);
          fails++;
        end
        if (got.pos_y !== want.pos_y) begin
          $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y);
          fails++;
        end
        if (got.placed_width !== want.placed_width) begin
          $error("placed_width exp %0d got %0d", want.placed_width, got.placed_width);
          fails++;
        end
        if (got.placed_height !== want.placed_height) begin
          $error("placed_height exp %0d got %0d", want.placed_height, got.placed_height);
          fails++;
        end
        if (got.turned !== want.turned) begin
          $error("turned exp %0d got %0d", want.turned, got.turned);
          fails++;
        end
        if (got.fitted !== want.fitted) begin
          $error("fitted exp %0d got %0d", want.fitted, got.fitted);
          fails++;
        end
        if (got.last_result !== want.last_result) begin
          $error("last_result exp %0d got %0d", want.last_result, got.last_result);
          fails++;
        end
      end
    end
  end

  task automatic send_command(logic [1:0] act, int w, int h);
    in_item_t c;
    c.action = act;
    c.sprite_width = COORD_BITS'(w);
    c.sprite_height = COORD_BITS'(h);
    in_ch.valid <= 1;
    in_ch.item <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_command(c);
    // burst then gap
    if ($urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // wait until every result has come and the block is idle again
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (placements_due.size() != 0 || !in_ch.ready) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_BITS'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_regs(int w, int h, int p, int r);
    write_reg(CFG_ATLAS_W, w);
    write_reg(CFG_ATLAS_H, h);
    write_reg(CFG_PAD, p);
    write_reg(CFG_ALLOW_ROT, r);
  endtask

  function automatic int rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 8191);
      1: return $urandom_range(1, 4);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  task automatic test_directed();
    send_command(ACT_PACK, 0, 0);             // nothing loaded
    send_command(ACT_LOAD, 4096, 4096);
    send_command(ACT_LOAD, 1, 1);
    send_command(ACT_LOAD, 8191, 1);
    send_command(ACT_LOAD, 0, 0);
    send_command(ACT_LOAD, 100, 50);
    send_command(ACT_LOAD, 50, 100);          // equal area, load order kept
    send_command(ACT_UNUSED, 8191, 8191);     // unknown action
    send_command(ACT_PACK, 0, 0);
    send_command(ACT_CLEAR, 0, 0);
    send_command(ACT_LOAD, 300, 20);
    send_command(ACT_LOAD, 20, 200);
    send_command(ACT_PACK, 0, 0);
    drain();
    set_regs(4096, 4096, 255, 1);
    send_command(ACT_LOAD, 8191, 8191);
    send_command(ACT_LOAD, 1000, 3000);
    send_command(ACT_LOAD, 3000, 1000);
    send_command(ACT_PACK, 0, 0);
    send_command(ACT_CLEAR, 0, 0);
    drain();
    set_regs(0, 0, 0, 0);                     // zero atlas, only zero sprites fit
    send_command(ACT_LOAD, 0, 0);
    send_command(ACT_LOAD, 1, 1);
    send_command(ACT_PACK, 0, 0);
    send_command(ACT_CLEAR, 0, 0);
    drain();
  endtask

  // fill beyond the sprite list cap, then pack the small sprites twice
  task automatic test_full_list();
    set_regs(8191, 8191, 0, 1);
    for (int i = 0; i < 70; i++) send_command(ACT_LOAD, $urandom_range(1, 8), 1);
    hold_off <= 400;                          // receiver blocks, result beat is held
    send_command(ACT_PACK, 0, 0);
    send_command(ACT_PACK, 0, 0);
    send_command(ACT_CLEAR, 0, 0);
    drain();
  endtask

  task automatic test_random();
    int n;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(1, 1, 0, 0);
        1: set_regs(1024, 1024, 0, 1);
        2: set_regs($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 255), 1);
        3: set_regs(512, 256, $urandom_range(0, 8), 0);
        4: set_regs(4096, 1, 1, 1);
        default: set_regs($urandom_range(64, 2048), $urandom_range(64, 2048), 2, 1);
      endcase
      no_stall = (ph == 3);
      for (int g = 0; g < 6; g++) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send_command(ACT_LOAD, rand_size(), rand_size());
        if ($urandom_range(0, 5) == 0) send_command(ACT_UNUSED, rand_size(), rand_size());
        send_command(ACT_PACK, 0, 0);
        if ($urandom_range(0, 3) == 0) send_command(ACT_LOAD, rand_size(), rand_size());
        send_command(ACT_CLEAR, 0, 0);
        if (g == 2) drain();                  // sender waits for all results
      end
      drain();
    end
    no_stall = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_random();
    drain();
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

FILE: guillotine_rect_packer_top.f
rtl/grp_pkg.sv
rtl/grp_in_if.sv
rtl/grp_out_if.sv
rtl/grp_cfg_if.sv
rtl/grp_ram.sv
rtl/grp_fit_eval.sv
rtl/guillotine_rect_packer_top.sv
bench/grp_tb_pkg.sv
bench/testbench.sv
